FILE: sv/hslc_pkg.sv
// Shared types and constants for the HTTP status line checker.
// Used by hslc_class, hslc_parse and http_status_line_checker; no dependencies.
`default_nettype none

package hslc_pkg;

  // Recognizer states, one-hot
  typedef enum logic [12:0] {
    PS_START     = 13'b0000000000001,
    PS_H         = 13'b0000000000010,
    PS_HT        = 13'b0000000000100,
    PS_HTT       = 13'b0000000001000,
    PS_HTTP      = 13'b0000000010000,
    PS_MAJ_FIRST = 13'b0000000100000,
    PS_MAJ       = 13'b0000001000000,
    PS_MIN_FIRST = 13'b0000010000000,
    PS_MIN       = 13'b0000100000000,
    PS_CODE      = 13'b0001000000000,
    PS_AFTER     = 13'b0010000000000,
    PS_TEXT      = 13'b0100000000000,
    PS_ALMOST    = 13'b1000000000000
  } parse_state_t;

  typedef enum logic [1:0] {
    V_MORE   = 2'd0,
    V_ACCEPT = 2'd1,
    V_MASKED = 2'd2,
    V_SYNTAX = 2'd3
  } verdict_t;

  // Class codes; also the bit index into the accept mask
  localparam logic [2:0] CLS_2XX   = 3'd0;
  localparam logic [2:0] CLS_3XX   = 3'd1;
  localparam logic [2:0] CLS_4XX   = 3'd2;
  localparam logic [2:0] CLS_5XX   = 3'd3;
  localparam logic [2:0] CLS_OTHER = 3'd4;

  localparam int unsigned MASK_W = 5;
  localparam int unsigned CODE_W = 10;

  localparam logic [MASK_W-1:0] MASK_RESET = 5'd1;

  // Characters
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Code range bounds
  localparam logic [CODE_W-1:0] CODE_200 = 10'd200;
  localparam logic [CODE_W-1:0] CODE_300 = 10'd300;
  localparam logic [CODE_W-1:0] CODE_400 = 10'd400;
  localparam logic [CODE_W-1:0] CODE_500 = 10'd500;
  localparam logic [CODE_W-1:0] CODE_600 = 10'd600;

  // Parser context carried from word to word
  typedef struct packed {
    parse_state_t      pstate;
    logic [CODE_W-1:0] accum;
    logic [1:0]        dcount;
  } parse_ctx_t;

  localparam parse_ctx_t CTX_RESET = '{pstate: PS_START, accum: '0, dcount: '0};

  // One result word
  typedef struct packed {
    verdict_t          verdict;
    logic [CODE_W-1:0] code;
    logic [2:0]        cls;
    logic              fault;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/hslc_class.sv
// Status code classifier: 2xx/3xx/4xx/5xx/other and the peer fault flag.
// Depends on hslc_pkg.
`default_nettype none

module hslc_class
  import hslc_pkg::*;
(
  input  wire logic [CODE_W-1:0] code,
  output logic      [2:0]        cls,
  output logic                   fault
);

  // Range compares on the completed code
  always_comb begin
    if (code >= CODE_200 && code < CODE_300) begin
      cls = CLS_2XX;
    end else if (code >= CODE_300 && code < CODE_400) begin
      cls = CLS_3XX;
    end else if (code >= CODE_400 && code < CODE_500) begin
      cls = CLS_4XX;
    end else if (code >= CODE_500 && code < CODE_600) begin
      cls = CLS_5XX;
    end else begin
      cls = CLS_OTHER;
    end
  end

  // Anything but 2xx and 3xx is the peer's fault
  assign fault = (cls != CLS_2XX) && (cls != CLS_3XX);

endmodule

`default_nettype wire

FILE: sv/hslc_parse.sv
// One recognizer step: next parser context and the result word for one byte.
// Depends on hslc_pkg and hslc_class.
`default_nettype none

module hslc_parse
  import hslc_pkg::*;
(
  input  wire parse_ctx_t        ctx,
  input  wire logic [7:0]        data_byte,
  input  wire logic              restart,
  input  wire logic [MASK_W-1:0] accept_mask,
  output parse_ctx_t             ctx_next,
  output result_t                res
);

  parse_ctx_t        cur;
  parse_ctx_t        stepped;
  logic              bad;
  logic              done;
  logic              is_digit;
  logic [CODE_W-1:0] times10;
  logic [CODE_W-1:0] accum_add;
  logic [1:0]        dcount_inc;
  logic [2:0]        cls;
  logic              fault;

  // Restart clears before the byte is looked at
  assign cur = restart ? CTX_RESET : ctx;

  assign is_digit   = (data_byte >= CH_0) && (data_byte <= CH_9);
  assign times10    = {cur.accum[6:0], 3'b000} + {cur.accum[8:0], 1'b0};
  assign accum_add  = times10 + {6'd0, data_byte[3:0]};
  assign dcount_inc = cur.dcount + 2'd1;

  // State transitions
  always_comb begin
    stepped = cur;
    bad     = 1'b0;
    done    = 1'b0;
    case (cur.pstate)
      PS_H: begin
        if (data_byte == CH_T) stepped.pstate = PS_HT; else bad = 1'b1;
      end
      PS_HT: begin
        if (data_byte == CH_T) stepped.pstate = PS_HTT; else bad = 1'b1;
      end
      PS_HTT: begin
        if (data_byte == CH_P) stepped.pstate = PS_HTTP; else bad = 1'b1;
      end
      PS_HTTP: begin
        if (data_byte == CH_SLASH) stepped.pstate = PS_MAJ_FIRST; else bad = 1'b1;
      end
      PS_MAJ_FIRST: begin
        if (data_byte >= CH_1 && data_byte <= CH_9) stepped.pstate = PS_MAJ;
        else bad = 1'b1;
      end
      PS_MAJ: begin
        if (data_byte == CH_DOT) stepped.pstate = PS_MIN_FIRST;
        else if (!is_digit) bad = 1'b1;
      end
      PS_MIN_FIRST: begin
        if (is_digit) stepped.pstate = PS_MIN; else bad = 1'b1;
      end
      PS_MIN: begin
        if (data_byte == CH_SPACE) stepped.pstate = PS_CODE;
        else if (!is_digit) bad = 1'b1;
      end
      PS_CODE: begin
        // spaces between digits are skipped
        if (data_byte != CH_SPACE) begin
          if (!is_digit) begin
            bad = 1'b1;
          end else begin
            stepped.accum  = accum_add;
            stepped.dcount = dcount_inc;
            if (dcount_inc == 2'd3) stepped.pstate = PS_AFTER;
          end
        end
      end
      PS_AFTER: begin
        if (data_byte == CH_SPACE || data_byte == CH_DOT) stepped.pstate = PS_TEXT;
        else if (data_byte == CH_CR) stepped.pstate = PS_ALMOST;
        else if (data_byte == CH_LF) done = 1'b1;
        else bad = 1'b1;
      end
      PS_TEXT: begin
        if (data_byte == CH_CR) stepped.pstate = PS_ALMOST;
        else if (data_byte == CH_LF) done = 1'b1;
      end
      PS_ALMOST: begin
        if (data_byte == CH_LF) done = 1'b1; else bad = 1'b1;
      end
      default: begin
        if (data_byte == CH_H) stepped.pstate = PS_H; else bad = 1'b1;
      end
    endcase
  end

  hslc_class u_class (
    .code  (stepped.accum),
    .cls   (cls),
    .fault (fault)
  );

  // Result word and context update
  always_comb begin
    res.code    = stepped.accum;
    res.cls     = 3'd0;
    res.fault   = 1'b0;
    res.verdict = V_MORE;
    ctx_next    = stepped;
    if (bad) begin
      res.verdict = V_SYNTAX;
      ctx_next    = CTX_RESET;
    end else if (done) begin
      res.cls     = cls;
      res.fault   = fault;
      res.verdict = accept_mask[cls] ? V_ACCEPT : V_MASKED;
      ctx_next    = CTX_RESET;
    end
  end

endmodule

`default_nettype wire

FILE: sv/http_status_line_checker.sv
// HTTP status line checker, top level.
// Path: each byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle unless out_ready stalls; the input and result registers
// are set apart by one parse step, and the input register refills while a result waits.
// Reset (rst, synchronous): parser to start, accept mask to 2xx only, both stages empty.
// Depends on hslc_pkg, hslc_parse, hslc_class.
`default_nettype none

module http_status_line_checker
  import hslc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wen,
  input  wire logic [MASK_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic              restart,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [1:0]        verdict,
  output logic      [CODE_W-1:0] status_code,
  output logic      [2:0]        status_class,
  output logic                   peer_fault
);

  logic [MASK_W-1:0] accept_mask;
  parse_ctx_t        ctx;
  parse_ctx_t        ctx_next;
  logic              held_valid;
  logic [7:0]        held_byte;
  logic              held_restart;
  result_t           res_next;
  result_t           res;
  logic              advance;

  // Held word moves to the result register when that slot is free
  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      accept_mask <= MASK_RESET;
    end else if (cfg_wen) begin
      accept_mask <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte    <= data_byte;
      held_restart <= restart;
    end
  end

  hslc_parse u_parse (
    .ctx         (ctx),
    .data_byte   (held_byte),
    .restart     (held_restart),
    .accept_mask (accept_mask),
    .ctx_next    (ctx_next),
    .res         (res_next)
  );

  // Parser context
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= CTX_RESET;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign verdict      = res.verdict;
  assign status_code  = res.code;
  assign status_class = res.cls;
  assign peer_fault   = res.fault;

endmodule

`default_nettype wire
